// ===== hw/rtl/aebr_pkg.sv =====
// Package for the byte-renormalising arithmetic encoder.
// Holds op codes, constants and the front-to-back command struct; no dependencies.
package aebr_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [31:0] RENORM_LIMIT = 32'h0100_0000;
  localparam logic [31:0] FINISH_ADD   = 32'h0080_0000;
  localparam logic [31:0] FINISH_WIDTH = 32'h0000_FFFF;
  localparam int unsigned MAX_SHIFTS   = 4;

  // classified command passed from the front end to the coder
  typedef struct packed {
    logic        finish;   // else encode
    logic        last_sym; // upper bound is range_width itself
    logic [31:0] lo_word;
    logic [31:0] hi_word;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [31:0] repeat_count;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/aebr_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module aebr_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/aebr_front.sv =====
// Front end: accepts items, writes the cumulative table, reads both bounds
// for encode items and queues commands. Depends on aebr_pkg and aebr_ram.
module aebr_front #(
  parameter int TableDepth = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        op,
  input  logic [7:0]        table_index,
  input  logic [31:0]       table_word,
  input  logic [7:0]        symbol,
  input  logic [8:0]        symbol_count,
  output logic              cmd_valid,
  output aebr_pkg::cmd_t    cmd,
  input  logic              cmd_take
);
  import aebr_pkg::*;
  localparam int AW = $clog2(TableDepth);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD1  = 2'd1;
  localparam logic [1:0] ST_RD2  = 2'd2;

  logic [1:0]  state;
  logic [8:0]  sym_q;
  logic        last_q;
  logic [31:0] lo_q;
  logic [8:0]  eff_count;
  logic        we;
  logic [AW-1:0] raddr;
  logic [31:0] rdata;
  logic        q_full;
  cmd_t        q_data;
  logic        accept;

  always_comb begin
    if (symbol_count == 9'd0) eff_count = 9'd1;
    else if (symbol_count > 9'(TableDepth)) eff_count = 9'(TableDepth);
    else eff_count = symbol_count;
  end

  assign full   = (state != ST_IDLE) || q_full;
  assign accept = push && !full;
  assign we     = accept && op == OP_LOAD && {1'b0, table_index} < 9'(TableDepth);
  // the entry at sym is read on the accepting edge, the one at sym+1 in ST_RD1, the cycle after
  assign raddr  = (state == ST_RD1) ? AW'(sym_q + 9'd1) : AW'(symbol);

  aebr_ram #(.Width(32), .Depth(TableDepth)) u_table (
    .clk(clk), .we(we), .waddr(table_index[AW-1:0]), .wdata(table_word),
    .raddr(raddr), .rdata(rdata)
  );

  // one-entry command queue; taken by the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      q_full <= 1'b0;
    end else begin
      if (cmd_take) q_full <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && op == OP_ENCODE && {1'b0, symbol} < eff_count) begin
            sym_q  <= {1'b0, symbol};
            last_q <= ({1'b0, symbol} == eff_count - 9'd1);
            state  <= ST_RD1;
          end else if (accept && op == OP_FINISH) begin
            q_full        <= 1'b1;
            q_data.finish <= 1'b1;
          end
        end
        ST_RD1: begin
          state <= ST_RD2;
        end
        ST_RD2: begin
          q_data.finish   <= 1'b0;
          q_data.last_sym <= last_q;
          q_data.lo_word  <= lo_q;
          q_data.hi_word  <= rdata;
          q_full          <= 1'b1;
          state           <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // rdata in ST_RD1 is the entry at sym; in ST_RD2 it is the entry at sym+1
  always_ff @(posedge clk) begin
    if (state == ST_RD1) lo_q <= rdata;
  end

  assign cmd_valid = q_full;
  assign cmd       = q_data;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> full) else $error("accept while reading table");
  a_rd_seq: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD1 |=> state == ST_RD2) else $error("table read sequence broken");
  a_q_fill: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD2 |=> q_full) else $error("command lost");
`endif
endmodule

// ===== hw/rtl/aebr_coder.sv =====
// Back end: interval update with two multipliers, carry, renormalisation and
// run-length output register. Depends on aebr_pkg.
module aebr_coder (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  aebr_pkg::cmd_t    cmd,
  output logic              cmd_take,
  output logic              empty,
  input  logic              pop,
  output aebr_pkg::res_t    res
);
  import aebr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_CARRY = 3'd3;
  localparam logic [2:0] ST_NORM  = 3'd4;
  localparam logic [2:0] ST_FL1   = 3'd5;
  localparam logic [2:0] ST_FL2   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]  state;
  logic [31:0] range_base, range_width;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic [31:0] ff_run_count;
  logic [2:0]  shifts;
  logic        carry_flag;
  logic        carry_step;  // second half of a two-run emission (carry or renormalisation)
  cmd_t        c;
  logic [31:0] lo, hi;
  logic [63:0] prod_lo, prod_hi;

  // single output register for the next result, and the emit decode of this state
  logic        out_v;
  res_t        out_r;
  logic        emitting;
  res_t        em;
  logic        stall;

  assign prod_lo = {32'd0, range_width} * {32'd0, c.lo_word};
  assign prod_hi = {32'd0, range_width} * {32'd0, c.hi_word};

  assign empty = !out_v;
  assign res   = out_r;
  // an emit may go only if the output register is free or being taken
  assign stall = out_v && !pop;
  assign cmd_take = (state == ST_IDLE) && cmd_valid && !stall;

  logic [7:0] top;
  assign top = range_base[31:24];

  // emit decode: the run, if any, that the current state emits; last is set at the item's end
  always_comb begin
    emitting = 1'b0;
    em       = '0;
    case (state)
      ST_CARRY: begin
        if (carry_flag && ff_run_count != 32'd0) begin
          if (!carry_step && held_valid) begin
            emitting        = 1'b1;
            em.byte_value   = held_byte + 8'd1;
            em.repeat_count = 32'd1;
          end else if (ff_run_count > 32'd1) begin
            emitting        = 1'b1;
            em.byte_value   = 8'd0;
            em.repeat_count = ff_run_count - 32'd1;
          end
        end
      end
      ST_NORM: begin
        if (shifts < 3'(MAX_SHIFTS) && range_width < RENORM_LIMIT && top != 8'hFF) begin
          if (!carry_step && held_valid) begin
            emitting        = 1'b1;
            em.byte_value   = held_byte;
            em.repeat_count = 32'd1;
          end else if (ff_run_count != 32'd0) begin
            emitting        = 1'b1;
            em.byte_value   = 8'hFF;
            em.repeat_count = ff_run_count;
          end
        end
      end
      ST_FL1: begin
        if (held_valid) begin
          emitting        = 1'b1;
          em.byte_value   = held_byte;
          em.repeat_count = 32'd1;
        end
      end
      ST_FL2: begin
        if (ff_run_count != 32'd0) begin
          emitting        = 1'b1;
          em.byte_value   = 8'hFF;
          em.repeat_count = ff_run_count;
        end
      end
      default: ;
    endcase
  end

  // A result is held one step so that its last flag is known when it is written:
  // pend_* holds the newest emitted result until the next one or the item's end.
  logic pend_v;
  res_t pend;
  logic item_end;
  logic can_move;
  logic load_out;

  assign item_end = (state == ST_DONE);
  assign can_move = !stall;
  assign load_out = can_move && pend_v && (emitting || item_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      range_base   <= 32'd0;
      range_width  <= 32'hFFFF_FFFF;
      held_byte    <= 8'd0;
      held_valid   <= 1'b0;
      ff_run_count <= 32'd0;
      out_v        <= 1'b0;
      pend_v       <= 1'b0;
      carry_step   <= 1'b0;
      carry_flag   <= 1'b0;
      shifts       <= 3'd0;
    end else begin
      if (pop && out_v && !load_out) out_v <= 1'b0;
      if (can_move) begin
        if (emitting) begin
          pend   <= em;
          pend_v <= 1'b1;
          if (pend_v) begin
            out_r <= pend;
            out_v <= 1'b1;
          end
        end else if (item_end && pend_v) begin
          out_r  <= '{byte_value: pend.byte_value, repeat_count: pend.repeat_count,
                     last: 1'b1};
          out_v  <= 1'b1;
          pend_v <= 1'b0;
        end
        case (state)
          ST_IDLE: begin
            if (cmd_valid) begin
              c     <= cmd;
              state <= cmd.finish ? ST_ADD : ST_MUL;
            end
          end
          ST_MUL: begin
            lo    <= prod_lo[63:32];
            hi    <= c.last_sym ? range_width : prod_hi[63:32];
            state <= ST_ADD;
          end
          ST_ADD: begin
            if (c.finish) begin
              range_base  <= range_base + FINISH_ADD;
              range_width <= FINISH_WIDTH;
              carry_flag  <= (range_base + FINISH_ADD) < range_base;
            end else begin
              range_base  <= range_base + lo;
              range_width <= hi - lo;
              carry_flag  <= (range_base + lo) < range_base;
            end
            carry_step <= 1'b0;
            state      <= ST_CARRY;
          end
          ST_CARRY: begin
            if (carry_flag && ff_run_count != 32'd0 && !carry_step && held_valid
                && ff_run_count > 32'd1) begin
              carry_step <= 1'b1;
            end else begin
              if (carry_flag) begin
                if (ff_run_count != 32'd0) begin
                  held_byte    <= 8'd0;
                  held_valid   <= 1'b1;
                  ff_run_count <= 32'd0;
                end else if (held_valid) begin
                  held_byte <= held_byte + 8'd1;
                end
              end
              carry_step <= 1'b0;
              shifts     <= 3'd0;
              state      <= ST_NORM;
            end
          end
          ST_NORM: begin
            if (shifts < 3'(MAX_SHIFTS) && range_width < RENORM_LIMIT) begin
              if (top == 8'hFF) begin
                if (ff_run_count != 32'hFFFF_FFFF) ff_run_count <= ff_run_count + 32'd1;
                range_width <= range_width << 8;
                range_base  <= range_base << 8;
                shifts      <= shifts + 3'd1;
              end else if (!carry_step && held_valid && ff_run_count != 32'd0) begin
                carry_step <= 1'b1;
              end else begin
                ff_run_count <= 32'd0;
                held_byte    <= top;
                held_valid   <= 1'b1;
                carry_step   <= 1'b0;
                range_width  <= range_width << 8;
                range_base   <= range_base << 8;
                shifts       <= shifts + 3'd1;
              end
            end else begin
              state <= c.finish ? ST_FL1 : ST_DONE;
            end
          end
          ST_FL1: state <= ST_FL2;
          ST_FL2: begin
            range_base   <= 32'd0;
            range_width  <= 32'hFFFF_FFFF;
            held_byte    <= 8'd0;
            held_valid   <= 1'b0;
            ff_run_count <= 32'd0;
            state        <= ST_DONE;
          end
          ST_DONE: state <= ST_IDLE;
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !pop |=> out_v && $stable(out_r)) else $error("result dropped");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> state == ST_IDLE) else $error("command taken while busy");
  a_pend_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v) else $error("result left pending");
`endif
endmodule

// ===== hw/rtl/arithmetic_encoder_byte_renorm_unit.sv =====
// Top level of the byte-renormalising arithmetic encoder.
// Depends on aebr_pkg, aebr_front and aebr_coder.
//
// Input channel: push/full. op 0 loads cum_table[table_index] with table_word,
// op 1 encodes symbol, op 2 finishes the message and flushes held bytes.
// Result channel: empty/pop; each result is a (byte_value, repeat_count) run,
// with last set on the final result of an item. Items with no result give none.
// Config: APB, register 0 at address 0 is symbol_count (reset 256).
// Sequence: an encode item takes two registered table reads in the front end,
// then the coder's multiply, add, carry and renormalise steps (a step per byte
// shift, an extra step where two runs are emitted) and done. A finish is
// queued at once and runs add, carry, renormalise (always two byte shifts),
// the flush steps and done; loads write the table on accept. An item's final
// result is written out in the coder's done step. The front end reads the
// next item's table entries while the coder works, via a one-entry queue.
// A stalled result (pop low) holds the coder; full is high during the front
// end's table reads and while the queue holds a command.
// Reset clears the interval state and register; the table stays undefined
// until written and needs no clearing pass.
module arithmetic_encoder_byte_renorm_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [7:0]  table_index,
  input  logic [31:0] table_word,
  input  logic [7:0]  symbol,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  byte_value,
  output logic [31:0] repeat_count,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import aebr_pkg::*;

  logic [8:0] symbol_count;
  logic       cmd_valid, cmd_take;
  cmd_t       cmd;
  res_t       res;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {23'd0, symbol_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= 9'd256;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      symbol_count <= pwdata[8:0];
    end
  end

  aebr_front #(.TableDepth(TABLE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .table_index(table_index), .table_word(table_word), .symbol(symbol),
    .symbol_count(symbol_count), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take)
  );

  aebr_coder u_coder (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .empty(empty), .pop(pop), .res(res)
  );

  assign byte_value   = res.byte_value;
  assign repeat_count = res.repeat_count;
  assign last         = res.last;
endmodule
